### src/hgar_pkg.sv
// ----------------------------------------------------------------------------
// hgar_pkg
// Shared types, constants and helper functions of the hex grid route search
// ----------------------------------------------------------------------------
package hgar_pkg;

  localparam int MAX_COLS = 8;
  localparam int MAX_ROWS = 8;
  localparam int CELLS    = MAX_COLS * MAX_ROWS;
  localparam int CRD_W    = 3;
  localparam int DIM_W    = 4;
  localparam int ID_W     = 2 * CRD_W;
  localparam int CNT_W    = ID_W + 1;
  localparam int G_W      = ID_W;
  localparam int H_W      = CRD_W + 1;
  localparam int F_W      = G_W + 1;
  localparam int NB_W     = 3;
  localparam logic [NB_W-1:0] NB_LAST = 3'd5;

  typedef logic [ID_W-1:0]  id_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SCAN_INIT,
    OP_SCAN,
    OP_POP,
    OP_SHIFT,
    OP_NB_A,
    OP_NB_B,
    OP_EMIT_NONE,
    OP_EMIT_END,
    OP_RT_NEXT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic scan_done;
    logic shift_done;
    logic hit;
    logic need_b;
    logic nb_last;
    logic o_last;
  } stat_t;

  function automatic logic [H_W-1:0] absdiff(input logic [CRD_W-1:0] a,
                                             input logic [CRD_W-1:0] b);
    logic [CRD_W-1:0] d;
    d = (a > b) ? a - b : b - a;
    return {1'b0, d};
  endfunction

  function automatic logic [H_W-1:0] heur(input id_t c, input id_t e);
    return absdiff(c[CRD_W-1:0], e[CRD_W-1:0]) + absdiff(c[ID_W-1:CRD_W], e[ID_W-1:CRD_W]);
  endfunction

  function automatic logic signed [1:0] nb_dx(input logic odd, input logic [NB_W-1:0] n);
    logic signed [1:0] d;
    d = 2'sd0;
    if (odd) begin
      case (n)
        3'd1, 3'd2, 3'd5: d = 2'sd1;
        3'd3:             d = -2'sd1;
        default:          d = 2'sd0;
      endcase
    end else begin
      case (n)
        3'd0, 3'd2, 3'd4: d = -2'sd1;
        3'd1:             d = 2'sd1;
        default:          d = 2'sd0;
      endcase
    end
    return d;
  endfunction

  function automatic logic signed [1:0] nb_dy(input logic odd, input logic [NB_W-1:0] n);
    logic signed [1:0] d;
    d = 2'sd0;
    if (odd) begin
      case (n)
        3'd0, 3'd2:       d = -2'sd1;
        3'd4, 3'd5:       d = 2'sd1;
        default:          d = 2'sd0;
      endcase
    end else begin
      case (n)
        3'd2, 3'd3:       d = 2'sd1;
        3'd4, 3'd5:       d = -2'sd1;
        default:          d = 2'sd0;
      endcase
    end
    return d;
  endfunction

endpackage

### src/hgar_dp.sv
// ----------------------------------------------------------------------------
// hgar_dp
// Datapath: open list, cost and parent memories, cell flags and result register
// ----------------------------------------------------------------------------
module hgar_dp import hgar_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  output stat_t            st,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [DIM_W-1:0] cfg_data,
  input  logic [CRD_W-1:0] in_sx,
  input  logic [CRD_W-1:0] in_sy,
  input  logic [CRD_W-1:0] in_ex,
  input  logic [CRD_W-1:0] in_ey,
  output logic             o_found,
  output logic [CRD_W-1:0] o_x,
  output logic [CRD_W-1:0] o_y,
  output logic             o_last
);

  logic [DIM_W-1:0] grid_cols, grid_rows, cols_c, rows_c;
  id_t              start_id, end_id, cur_id, best_id, s2_id, rt_addr;
  logic [G_W-1:0]   cur_g, best_g;
  logic [F_W-1:0]   best_f, s2_f;
  cnt_t             cnt, i, s1_i, s2_i, best_i, r;
  logic             s1_v, s2_v, best_v, sh_v;
  id_t              sh_w;
  logic [NB_W-1:0]  n;
  logic [CELLS-1:0] closed_f, open_f;

  id_t              lmem [CELLS];
  logic [G_W-1:0]   gmem [CELLS];
  id_t              pmem [CELLS];
  id_t              l_rd, p_rd;
  logic [G_W-1:0]   g_rd;

  id_t              l_ra, g_ra, l_wa;
  id_t              l_wd;
  logic             l_we, g_we;
  id_t              g_wa;
  logic [G_W-1:0]   g_wd;

  logic signed [4:0] nx, ny;
  logic              nb_in, nb_cl, nb_op, append;
  id_t               nb_id;
  logic [G_W-1:0]    ng;
  logic              start_ok;

  assign cols_c = (grid_cols > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : grid_cols;
  assign rows_c = (grid_rows > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : grid_rows;
  assign start_ok = ({1'b0, in_sx} < cols_c) && ({1'b0, in_sy} < rows_c);

  // neighbour of the current cell
  always_comb begin
    nx    = $signed({2'b00, cur_id[CRD_W-1:0]})
          + 5'(nb_dx(cur_id[CRD_W], n));
    ny    = $signed({2'b00, cur_id[ID_W-1:CRD_W]})
          + 5'(nb_dy(cur_id[CRD_W], n));
    nb_in = !nx[4] && !ny[4] && (nx[3:0] < cols_c) && (ny[3:0] < rows_c);
    nb_id = {ny[CRD_W-1:0], nx[CRD_W-1:0]};
    nb_cl = closed_f[nb_id];
    nb_op = open_f[nb_id];
    ng    = cur_g + G_W'(1);
    append = (cmd.op == OP_NB_A) && nb_in && !nb_cl && !nb_op;
  end

  assign s2_f = F_W'(g_rd) + F_W'(heur(s2_id, end_id));

  always_comb begin
    st.empty      = (cnt == '0);
    st.scan_done  = (i >= cnt) && !s1_v && !s2_v;
    st.shift_done = (r > cnt) && !sh_v;
    st.hit        = append && (nb_id == end_id);
    st.need_b     = nb_in && !nb_cl && nb_op;
    st.nb_last    = (n == NB_LAST);
    st.o_last     = o_last;
  end

  // memory port selection
  always_comb begin
    l_ra = (cmd.op == OP_SHIFT) ? r[ID_W-1:0] : i[ID_W-1:0];
    g_ra = (cmd.op == OP_NB_A) ? nb_id : l_rd;
    l_we = 1'b0;
    l_wa = '0;
    l_wd = '0;
    g_we = 1'b0;
    g_wa = nb_id;
    g_wd = ng;
    unique case (cmd.op)
      OP_LOAD: begin
        l_we = 1'b1;
        l_wd = {in_sy, in_sx};
        g_we = 1'b1;
        g_wa = {in_sy, in_sx};
        g_wd = '0;
      end
      OP_SHIFT: begin
        l_we = sh_v;
        l_wa = sh_w;
        l_wd = l_rd;
      end
      OP_NB_A: begin
        l_we = append;
        l_wa = cnt[ID_W-1:0];
        l_wd = nb_id;
        g_we = append;
      end
      OP_NB_B: g_we = (g_rd > ng);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (l_we) lmem[l_wa] <= l_wd;
    if (g_we) gmem[g_wa] <= g_wd;
    if (g_we && cmd.op != OP_LOAD) pmem[g_wa] <= cur_id;
    l_rd <= lmem[l_ra];
    g_rd <= gmem[g_ra];
    p_rd <= pmem[rt_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols <= DIM_W'(MAX_COLS);
      grid_rows <= DIM_W'(MAX_ROWS);
    end else if (cfg_we) begin
      if (cfg_index) grid_rows <= cfg_data;
      else           grid_cols <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      closed_f <= '0;
      open_f   <= '0;
      s1_v     <= 1'b0;
      s2_v     <= 1'b0;
      sh_v     <= 1'b0;
      best_v   <= 1'b0;
      i        <= '0;
      r        <= '0;
      n        <= '0;
      o_found  <= 1'b0;
      o_x      <= '0;
      o_y      <= '0;
      o_last   <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_LOAD: begin
          start_id <= {in_sy, in_sx};
          end_id   <= {in_ey, in_ex};
          closed_f <= '0;
          open_f   <= CELLS'(start_ok) << {in_sy, in_sx};
          cnt      <= start_ok ? cnt_t'(1) : '0;
        end
        OP_SCAN_INIT: begin
          i      <= '0;
          s1_v   <= 1'b0;
          s2_v   <= 1'b0;
          best_v <= 1'b0;
        end
        OP_SCAN: begin
          s1_v <= (i < cnt);
          s1_i <= i;
          if (i < cnt) i <= i + cnt_t'(1);
          s2_v  <= s1_v;
          s2_id <= l_rd;
          s2_i  <= s1_i;
          if (s2_v && (!best_v || s2_f < best_f)) begin
            best_v  <= 1'b1;
            best_f  <= s2_f;
            best_i  <= s2_i;
            best_id <= s2_id;
            best_g  <= g_rd;
          end
        end
        OP_POP: begin
          cur_id            <= best_id;
          cur_g             <= best_g;
          closed_f[best_id] <= 1'b1;
          open_f[best_id]   <= 1'b0;
          cnt               <= cnt - cnt_t'(1);
          r                 <= best_i + cnt_t'(1);
          sh_v              <= 1'b0;
          n                 <= '0;
        end
        OP_SHIFT: begin
          sh_v <= (r <= cnt);
          sh_w <= ID_W'(r - cnt_t'(1));
          if (r <= cnt) r <= r + cnt_t'(1);
        end
        OP_NB_A: begin
          if (append) begin
            open_f[nb_id] <= 1'b1;
            cnt           <= cnt + cnt_t'(1);
          end
          if (!st.need_b) n <= n + NB_W'(1);
        end
        OP_NB_B: n <= n + NB_W'(1);
        OP_EMIT_NONE: begin
          o_found <= 1'b0;
          o_x     <= '0;
          o_y     <= '0;
          o_last  <= 1'b1;
        end
        OP_EMIT_END: begin
          o_found <= 1'b1;
          o_x     <= end_id[CRD_W-1:0];
          o_y     <= end_id[ID_W-1:CRD_W];
          o_last  <= 1'b0;
          rt_addr <= end_id;
        end
        OP_RT_NEXT: begin
          o_found <= 1'b1;
          o_x     <= p_rd[CRD_W-1:0];
          o_y     <= p_rd[ID_W-1:CRD_W];
          o_last  <= (p_rd == start_id);
          rt_addr <= p_rd;
        end
        default: ;
      endcase
    end
  end

endmodule

### src/hgar_ctrl.sv
// ----------------------------------------------------------------------------
// hgar_ctrl
// Controller: sequences load, best-entry scan, removal, expansion and route walk
// ----------------------------------------------------------------------------
module hgar_ctrl import hgar_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t st,
  output cmd_t  cmd
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_NEXT  = 12'b000000000010,
    S_SCANI = 12'b000000000100,
    S_SCAN  = 12'b000000001000,
    S_POP   = 12'b000000010000,
    S_SHIFT = 12'b000000100000,
    S_NBA   = 12'b000001000000,
    S_NBB   = 12'b000010000000,
    S_NONE  = 12'b000100000000,
    S_REND  = 12'b001000000000,
    S_RNEXT = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_t;

  state_t state, state_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_NEXT;
        end
      end
      S_NEXT:  state_next = st.empty ? S_NONE : S_SCANI;
      S_SCANI: begin
        cmd.op     = OP_SCAN_INIT;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.op = OP_SCAN;
        if (st.scan_done) state_next = S_POP;
      end
      S_POP: begin
        cmd.op     = OP_POP;
        state_next = S_SHIFT;
      end
      S_SHIFT: begin
        cmd.op = OP_SHIFT;
        if (st.shift_done) state_next = S_NBA;
      end
      S_NBA: begin
        cmd.op = OP_NB_A;
        priority if (st.hit)    state_next = S_REND;
        else if (st.need_b)     state_next = S_NBB;
        else if (st.nb_last)    state_next = S_NEXT;
        else                    state_next = S_NBA;
      end
      S_NBB: begin
        cmd.op     = OP_NB_B;
        state_next = st.nb_last ? S_NEXT : S_NBA;
      end
      S_NONE: begin
        cmd.op     = OP_EMIT_NONE;
        state_next = S_OUT;
      end
      S_REND: begin
        cmd.op     = OP_EMIT_END;
        state_next = S_OUT;
      end
      S_RNEXT: begin
        cmd.op     = OP_RT_NEXT;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_next = st.o_last ? S_IDLE : S_RNEXT;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule

### src/hex_grid_astar_route.sv
// ----------------------------------------------------------------------------
// hex_grid_astar_route
// A* route search on an offset hexagon grid, route emitted end to start
// ----------------------------------------------------------------------------
// one query at a time; input ready again after the last result transfer
// each expansion runs a scan of the open list, a removal shift and the checks of
// the six neighbour cells of the removed cell
// a start outside the grid gives a no-route result without a search; route cells
// follow one at a time, each after the previous one is taken
// synchronous reset: controller idle, grid set to 8 x 8, lists empty
module hex_grid_astar_route import hgar_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // start_x, start_y, end_x, end_y, zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // cell_x, cell_y, zero pad
  output logic        m_axis_tuser,  // found
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data
);

  cmd_t             cmd;
  stat_t            st;
  logic [CRD_W-1:0] o_x, o_y;

  hgar_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .st        (st),
    .cmd       (cmd)
  );

  hgar_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_sx     (s_axis_tdata[2:0]),
    .in_sy     (s_axis_tdata[5:3]),
    .in_ex     (s_axis_tdata[8:6]),
    .in_ey     (s_axis_tdata[11:9]),
    .o_found   (m_axis_tuser),
    .o_x       (o_x),
    .o_y       (o_y),
    .o_last    (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, o_y, o_x};

endmodule

### src/hgar_checker.sv
// ----------------------------------------------------------------------------
// hgar_checker
// Port-level checks of the route search block
// ----------------------------------------------------------------------------
module hgar_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tuser,
  input logic       m_axis_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("query taken while a result is pending");

  a_noroute: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == 8'd0))
    else $error("no-route result malformed");

  a_reset: assert property (@(posedge clk) rst |=> s_axis_tready && !m_axis_tvalid)
    else $error("not idle after reset");

endmodule

bind hex_grid_astar_route hgar_checker u_hgar_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
